// File: src/tcw_pkg.sv
// tcw_pkg: constants, command codes and state type for the text console writer
// no dependencies; used by text_console_writer_unit
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int COL_W   = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] ATTR_GREY    = 8'h07;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_RESULT
  } state_e;

endpackage

// File: src/text_console_writer_unit.sv
// text_console_writer_unit: character-cell console with cursor, wrap, newline and scroll
// depends on tcw_pkg; holds the character store as a single-port-write memory
`timescale 1ns / 1ps

// A write or no-op transaction goes from ST_IDLE to ST_RESULT; a read passes through
// ST_READ first (one registered memory read). Scrolling copies every row up one cell per
// cycle and then fills the bottom row, so a write that scrolls passes through ST_COPY,
// ST_DRAIN and ST_FILL; a clear passes through ST_FILL. After reset the store is filled
// with spaces, one cell per cycle, during which no input transaction is taken. The store's
// single write port sets this pace. The attribute output is always 0x07.
module text_console_writer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] char_code_i,
  input  logic [4:0] cell_row_i,
  input  logic [6:0] cell_column_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attribute_o,
  output logic [4:0] cursor_row_o,
  output logic [6:0] cursor_column_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int CW = tcw_pkg::COL_W;

  tcw_pkg::state_e state_q, state_d;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic          cp_v_q, cp_v_d;
  logic [AW-1:0] cp_dst_q, cp_dst_d;
  logic          rd_ok_q, rd_ok_d;
  logic [7:0]    res_char_q, res_char_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic [4:0]    out_row_q, out_row_d;
  logic [6:0]    out_col_q, out_col_d;

  logic [7:0]    mem [tcw_pkg::CELLS];
  logic [7:0]    rd_q;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data;

  logic          accept;
  logic          last_row, last_col, is_newline, scroll_need;
  logic [AW-1:0] cur_addr, req_addr;
  logic          req_ok;
  tcw_pkg::cmd_e cmd;

  assign cmd        = tcw_pkg::cmd_e'(command_i);
  assign in_stall_o = (state_q != tcw_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign last_row   = (cur_row_q == RW'(tcw_pkg::ROWS - 1));
  assign last_col   = (cur_col_q == CW'(tcw_pkg::COLUMNS - 1));
  assign is_newline = (char_code_i == tcw_pkg::CHAR_NEWLINE);
  assign scroll_need = (cmd == tcw_pkg::CMD_WRITE) && last_row && (is_newline || last_col);

  assign cur_addr = AW'(AW'(cur_row_q) * AW'(tcw_pkg::COLUMNS)) + AW'(cur_col_q);
  assign req_addr = AW'(AW'(cell_row_i) * AW'(tcw_pkg::COLUMNS)) + AW'(cell_column_i);
  assign req_ok   = (32'(cell_row_i) < tcw_pkg::ROWS) && (32'(cell_column_i) < tcw_pkg::COLUMNS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        if (ptr_q == AW'(tcw_pkg::CELLS - 1)) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            tcw_pkg::CMD_WRITE: state_d = scroll_need ? tcw_pkg::ST_COPY : tcw_pkg::ST_RESULT;
            tcw_pkg::CMD_CLEAR: state_d = tcw_pkg::ST_FILL;
            tcw_pkg::CMD_READ:  state_d = tcw_pkg::ST_READ;
            default:            state_d = tcw_pkg::ST_RESULT;
          endcase
        end
      end
      tcw_pkg::ST_READ: state_d = tcw_pkg::ST_RESULT;
      tcw_pkg::ST_COPY: begin
        if (ptr_q == AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1)) state_d = tcw_pkg::ST_DRAIN;
      end
      tcw_pkg::ST_DRAIN: state_d = tcw_pkg::ST_FILL;
      tcw_pkg::ST_FILL: begin
        if (ptr_q == AW'(tcw_pkg::CELLS - 1)) state_d = tcw_pkg::ST_RESULT;
      end
      tcw_pkg::ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_INIT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ptr_d       = ptr_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    cp_v_d      = 1'b0;
    cp_dst_d    = cp_dst_q;
    rd_ok_d     = rd_ok_q;
    res_char_d  = res_char_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    wr_en       = 1'b0;
    wr_addr     = ptr_q;
    wr_data     = tcw_pkg::CHAR_SPACE;
    rd_en       = 1'b0;
    rd_addr     = req_addr;

    case (state_q)
      tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
        wr_en = 1'b1;
        ptr_d = AW'(ptr_q + AW'(1));
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          res_char_d = 8'h00;
          ptr_d      = '0;
          case (cmd)
            tcw_pkg::CMD_WRITE: begin
              if (!is_newline) begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
                wr_data = char_code_i;
              end
              if (is_newline || last_col) begin
                cur_col_d = '0;
                if (!last_row) cur_row_d = RW'(cur_row_q + RW'(1));
              end else begin
                cur_col_d = CW'(cur_col_q + CW'(1));
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              cur_row_d = '0;
              cur_col_d = '0;
            end
            tcw_pkg::CMD_READ: begin
              rd_en   = 1'b1;
              rd_ok_d = req_ok;
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        res_char_d = rd_ok_q ? rd_q : 8'h00;
      end
      tcw_pkg::ST_COPY: begin
        rd_en    = 1'b1;
        rd_addr  = AW'(ptr_q + AW'(tcw_pkg::COLUMNS));
        cp_v_d   = 1'b1;
        cp_dst_d = ptr_q;
        wr_en    = cp_v_q;
        wr_addr  = cp_dst_q;
        wr_data  = rd_q;
        ptr_d    = AW'(ptr_q + AW'(1));
      end
      tcw_pkg::ST_DRAIN: begin
        wr_en   = 1'b1;
        wr_addr = cp_dst_q;
        wr_data = rd_q;
        ptr_d   = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
      end
      tcw_pkg::ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_char_d  = res_char_q;
          out_row_d   = 5'(cur_row_q);
          out_col_d   = 7'(cur_col_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_INIT;
      ptr_q       <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cp_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      cp_v_q      <= cp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_dst_q   <= cp_dst_d;
    rd_ok_q    <= rd_ok_d;
    res_char_q <= res_char_d;
    out_char_q <= out_char_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
  end

  // character store
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign out_valid_o      = out_valid_q;
  assign cell_char_o      = out_char_q;
  assign cell_attribute_o = tcw_pkg::ATTR_GREY;
  assign cursor_row_o     = out_row_q;
  assign cursor_column_o  = out_col_q;

endmodule
